/* hw/rtl/assert_macros.svh */
// Assertion macros used by the aging subscriber table module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define AST_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define AST_IMPLIES(label, clk, rst_n, pre, post)
`define AST_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* hw/rtl/ast_pkg.sv */
// Types and codes of the aging subscriber table.
// No dependencies.
`timescale 1ns / 1ps
package ast_pkg;
  localparam int KeyW = 48;
  localparam int TimeW = 32;
  localparam int AgeW = 16;
  localparam int SlotW = 6;

  localparam logic [1:0] KIND_KEEP = 2'd0;
  localparam logic [1:0] KIND_DEST = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] ACT_REFRESH = 2'd0;
  localparam logic [1:0] ACT_REPLACE = 2'd1;
  localparam logic [1:0] ACT_ADD = 2'd2;
  localparam logic [1:0] ACT_DROP = 2'd3;

  localparam logic OP_KEEP = 1'b0;
  localparam logic OP_FAN = 1'b1;

  localparam logic CFG_REPLACE = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  localparam logic [15:0] REPLACE_RST = 16'd90;
  localparam logic [15:0] ACTIVE_RST = 16'd65;

  // Entry carried along the rotating chain.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TimeW-1:0] heard;
  } entry_t;

  // Write command broadcast to every cell.
  typedef struct packed {
    logic en;
    logic [KeyW-1:0] key;
    logic [TimeW-1:0] heard;
  } wr_t;
endpackage

/* hw/rtl/ast_cell.sv */
// One cell of the rotating entry chain of the subscriber table.
// Depends on ast_pkg.
`timescale 1ns / 1ps
module ast_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            wr_here,
  input  ast_pkg::wr_t    wr,
  input  ast_pkg::entry_t d_in,
  output ast_pkg::entry_t q
);
  ast_pkg::entry_t ent_r;

  always_ff @(posedge clk) begin
    if (wr_here && wr.en) begin
      ent_r.key <= wr.key;
      ent_r.heard <= wr.heard;
    end else if (shift) begin
      ent_r <= d_in;
    end
  end

  assign q = ent_r;
endmodule

/* hw/rtl/aging_subscriber_table.sv */
// Aging subscriber table.
// Input items carry op on in_tuser and client_key with now_time on in_tdata;
// they are taken one at a time, only while the block is idle.
// Keepalive items give one result; fan-out items give one result per active
// entry in slot order, or one empty result, the final one marked by tlast.
// The kind of each result travels on out_tuser.
// Entries live in a ring of ENTRIES cells that rotates by one slot per cycle
// while an item is scanned or turned, but stands still while the head is
// written, and is back at slot 0 whenever the block is idle; the head cell is
// examined as it passes during the scan. A fan-out scans the ring once and
// registers its final result in S_EMIT. A keepalive scans, then turns the
// ring once more and writes the chosen slot as it passes the head (no write
// when it is dropped), and registers its result in S_EMIT. The input is ready
// again after S_WAIT, which follows the final result. While the receiver
// stalls, the scan holds and the ring freezes, and S_EMIT waits as well.
// Reset empties the table and loads the age registers with 90 and 65
// seconds; there is no clearing pass. Configuration is accepted only while
// the block is idle, and takes priority over a waiting input item.
// Depends on ast_pkg and ast_cell; assertions use assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aging_subscriber_table #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // op
  input  logic [79:0] in_tdata,   // client_key, now_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [55:0] out_tdata,  // action, slot, dest_key
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_ROT = 5'b00100,
    S_EMIT = 5'b01000, S_WAIT = 5'b10000
  } state_t;

  state_t st_r;
  logic [15:0] rep_age_r, act_age_r;
  logic [CW-1:0] used_r;
  logic [CW-1:0] pos_r;       // slot of head cell
  logic [CW-1:0] cnt_r;       // scanned cells
  logic op_r;
  logic [ast_pkg::KeyW-1:0] key_r;
  logic [ast_pkg::TimeW-1:0] now_r;
  logic match_r, exp_r, any_r, wdone_r;
  logic [IW-1:0] match_idx_r, exp_idx_r, tgt_r;
  logic [1:0] act_r;
  logic out_v_r, out_last_r;
  logic [57:0] out_d_r;
  logic pend_v_r;
  logic [57:0] pend_d_r;

  ast_pkg::entry_t q [ENTRIES];
  ast_pkg::wr_t wr;
  logic shift;
  logic wr_en;
  logic out_load;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      ast_cell u_cell (
        .clk(clk), .shift(shift), .wr_here(g == 0), .wr(wr),
        .d_in(q[(g + 1) % ENTRIES]), .q(q[g])
      );
    end
  endgenerate

  logic [IW-1:0] pos_idx;
  logic in_use;
  logic [ast_pkg::TimeW-1:0] age;
  logic hit_key, hit_exp, hit_act, out_free;

  assign pos_idx = pos_r[IW-1:0];
  assign in_use = pos_r < used_r;
  assign age = now_r - q[0].heard;
  assign hit_key = in_use && (q[0].key == key_r);
  assign hit_exp = in_use && (age > {16'd0, rep_age_r});
  assign hit_act = in_use && (age < {16'd0, act_age_r});
  assign out_free = !out_v_r || out_tready;

  // The ring stands still in the cycle in which the head is written.
  assign wr_en = (st_r == S_ROT) && (pos_idx == tgt_r) &&
                 (act_r != ast_pkg::ACT_DROP) && !wdone_r;
  assign shift = (st_r == S_SCAN && out_free) || (st_r == S_ROT && !wr_en);
  assign wr = {wr_en, key_r, now_r};

  assign out_load = (st_r == S_SCAN && out_free && op_r == ast_pkg::OP_FAN &&
                     hit_act && pend_v_r) || (st_r == S_EMIT && out_free);

  assign in_tready = (st_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (st_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tuser = out_d_r[1:0];
  assign out_tdata = out_d_r[57:2];
  assign out_tlast = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_age_r <= ast_pkg::REPLACE_RST;
      act_age_r <= ast_pkg::ACTIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ast_pkg::CFG_REPLACE) rep_age_r <= cfg_data;
      else act_age_r <= cfg_data;
    end
  end

  function automatic logic [57:0] pack_out(logic [1:0] k, logic [1:0] a,
                                           logic [IW-1:0] s,
                                           logic [ast_pkg::KeyW-1:0] d);
    logic [ast_pkg::SlotW-1:0] s6;
    s6 = ast_pkg::SlotW'(s);
    return {d, s6, a, k};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      used_r <= '0;
      pos_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tuser;
            key_r <= in_tdata[47:0];
            now_r <= in_tdata[79:48];
            cnt_r <= '0;
            match_r <= 1'b0;
            exp_r <= 1'b0;
            any_r <= 1'b0;
            wdone_r <= 1'b0;
            pend_v_r <= 1'b0;
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (out_free) begin
            pos_r <= (pos_r == CW'(ENTRIES - 1)) ? '0 : pos_r + 1'b1;
            cnt_r <= (cnt_r == CW'(ENTRIES - 1)) ? '0 : cnt_r + 1'b1;
            if (op_r == ast_pkg::OP_KEEP) begin
              if (hit_key && !match_r) begin
                match_r <= 1'b1;
                match_idx_r <= pos_idx;
              end
              if (hit_exp && !exp_r) begin
                exp_r <= 1'b1;
                exp_idx_r <= pos_idx;
              end
            end else if (hit_act) begin
              any_r <= 1'b1;
              if (pend_v_r) begin
                out_d_r <= pend_d_r;
                out_last_r <= 1'b0;
              end
              pend_v_r <= 1'b1;
              pend_d_r <= pack_out(ast_pkg::KIND_DEST, ast_pkg::ACT_REFRESH,
                                   pos_idx, q[0].key);
            end
            if (cnt_r == CW'(ENTRIES - 1)) begin
              if (op_r == ast_pkg::OP_FAN) st_r <= S_EMIT;
              else st_r <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (wr_en) begin
            wdone_r <= 1'b1;
          end else begin
            pos_r <= (pos_r == CW'(ENTRIES - 1)) ? '0 : pos_r + 1'b1;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CW'(ENTRIES - 1)) st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_last_r <= 1'b1;
            if (op_r == ast_pkg::OP_FAN) begin
              if (any_r) out_d_r <= pend_d_r;
              else out_d_r <= pack_out(ast_pkg::KIND_NONE, ast_pkg::ACT_REFRESH,
                                       '0, '0);
            end else begin
              out_d_r <= pack_out(ast_pkg::KIND_KEEP, act_r,
                                  (act_r == ast_pkg::ACT_DROP) ? '0 : tgt_r, key_r);
              if (act_r == ast_pkg::ACT_ADD) used_r <= used_r + 1'b1;
            end
            st_r <= S_WAIT;
          end
        end
        S_WAIT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Keepalive target chosen as scan ends; the last cell's hits are folded in
  // behind the flags of the earlier cells, and a drop makes no write.
  always_ff @(posedge clk) begin
    if (st_r == S_SCAN && out_free && cnt_r == CW'(ENTRIES - 1)) begin
      if (match_r) begin
        act_r <= ast_pkg::ACT_REFRESH;
        tgt_r <= match_idx_r;
      end else if (hit_key) begin
        act_r <= ast_pkg::ACT_REFRESH;
        tgt_r <= pos_idx;
      end else if (exp_r) begin
        act_r <= ast_pkg::ACT_REPLACE;
        tgt_r <= exp_idx_r;
      end else if (hit_exp) begin
        act_r <= ast_pkg::ACT_REPLACE;
        tgt_r <= pos_idx;
      end else if (used_r < CW'(ENTRIES)) begin
        act_r <= ast_pkg::ACT_ADD;
        tgt_r <= used_r[IW-1:0];
      end else begin
        act_r <= ast_pkg::ACT_DROP;
        tgt_r <= '0;
      end
    end
  end

  `AST_IMPLIES(a_used_max, clk, rst_n, 1'b1, used_r <= CW'(ENTRIES))
  `AST_IMPLIES(a_ready_idle, clk, rst_n, in_tready, !out_v_r || st_r == S_IDLE)
  `AST_NEXT(a_hold, clk, rst_n, out_v_r && !out_tready, out_v_r && $stable(out_d_r))
endmodule

/* bench/tb_aging_subscriber_table.sv */
// Self-checking bench for aging_subscriber_table: a scoreboard class predicts
// every result of each accepted item; plain tasks drive items and registers.
// Depends on ast_pkg and the aging_subscriber_table RTL.
`timescale 1ns / 1ps
module tb_aging_subscriber_table;
  localparam int Slots = 64;
  localparam longint LimitCycles = 3000000;

  class subscriber_scoreboard;
    typedef struct {
      logic [1:0] kind;
      logic [1:0] action;
      logic [5:0] slot;
      logic [47:0] key;
      logic last;
    } table_result_t;

    table_result_t expected_results[$];
    logic [47:0] keys[Slots];
    logic [31:0] heard[Slots];
    int used;
    logic [15:0] replace_age;
    logic [15:0] active_age;
    int mismatches;

    function new();
      used = 0;
      replace_age = ast_pkg::REPLACE_RST;
      active_age = ast_pkg::ACTIVE_RST;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] value);
      if (idx == ast_pkg::CFG_REPLACE) replace_age = value;
      else active_age = value;
    endfunction

    function void push(logic [1:0] kd, logic [1:0] a, int s, logic [47:0] k, logic l);
      table_result_t r;
      r.kind = kd;
      r.action = a;
      r.slot = s[5:0];
      r.key = k;
      r.last = l;
      expected_results.push_back(r);
    endfunction

    function void note_item(logic op, logic [47:0] key, logic [31:0] now);
      int count;
      int first;
      logic [31:0] age;
      if (op == ast_pkg::OP_KEEP) begin
        for (int i = 0; i < used; i++) begin
          if (keys[i] == key) begin
            heard[i] = now;
            push(ast_pkg::KIND_KEEP, ast_pkg::ACT_REFRESH, i, key, 1'b1);
            return;
          end
        end
        for (int i = 0; i < used; i++) begin
          age = now - heard[i];
          if (age > {16'd0, replace_age}) begin
            keys[i] = key;
            heard[i] = now;
            push(ast_pkg::KIND_KEEP, ast_pkg::ACT_REPLACE, i, key, 1'b1);
            return;
          end
        end
        if (used < Slots) begin
          keys[used] = key;
          heard[used] = now;
          push(ast_pkg::KIND_KEEP, ast_pkg::ACT_ADD, used, key, 1'b1);
          used++;
          return;
        end
        push(ast_pkg::KIND_KEEP, ast_pkg::ACT_DROP, 0, key, 1'b1);
        return;
      end
      count = 0;
      first = expected_results.size();
      for (int i = 0; i < used; i++) begin
        age = now - heard[i];
        if (age < {16'd0, active_age}) begin
          push(ast_pkg::KIND_DEST, ast_pkg::ACT_REFRESH, i, keys[i], 1'b0);
          count++;
        end
      end
      if (count == 0) push(ast_pkg::KIND_NONE, ast_pkg::ACT_REFRESH, 0, 48'd0, 1'b1);
      else expected_results[first + count - 1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [55:0] data, logic tl);
      table_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual kind %0d data %h last %b",
                 $time, kind, data, tl);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind || data[1:0] !== e.action || data[7:2] !== e.slot ||
          data[55:8] !== e.key || tl !== e.last) begin
        $display("%0t: mismatch, expected kind %0d action %0d slot %0d key %h last %b",
                 $time, e.kind, e.action, e.slot, e.key, e.last);
        $display("%0t:          actual   kind %0d action %0d slot %0d key %h last %b",
                 $time, kind, data[1:0], data[7:2], data[55:8], tl);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = 1'b0;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [1:0] out_tuser;
  logic [55:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = ast_pkg::CFG_REPLACE;
  logic [15:0] cfg_data = '0;

  subscriber_scoreboard board = new();
  int idle_mode = 0;
  int hold_off = 0;
  longint cycles = 0;
  logic [47:0] key_pool[72];
  logic [31:0] clock_now;

  aging_subscriber_table #(.ENTRIES(Slots)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("aging_subscriber_table verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (idle_mode == 2) out_tready <= ($urandom_range(99) >= 75);
    else if (idle_mode == 3) out_tready <= ($urandom_range(99) >= 28);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tuser, out_tdata, out_tlast);
  end

  function automatic bit sender_idles();
    if (idle_mode == 1) return $urandom_range(99) < 75;
    if (idle_mode == 3) return $urandom_range(99) < 28;
    return 1'b0;
  endfunction

  task automatic send_item(logic op, logic [47:0] key, logic [31:0] now);
    while (sender_idles()) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {now, key};
    do @(posedge clk); while (!in_tready);
    board.note_item(op, key, now);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int mode, int items, int pool_n, int step);
    logic op;
    logic [47:0] key;
    idle_mode = mode;
    for (int n = 0; n < items; n++) begin
      op = ($urandom_range(99) < 60) ? ast_pkg::OP_KEEP : ast_pkg::OP_FAN;
      if ($urandom_range(99) < 80) begin
        key = key_pool[$urandom_range(pool_n - 1)];
        clock_now = clock_now + $urandom_range(step);
      end else begin
        key = 48'({$urandom, $urandom});
        if ($urandom_range(3) == 0) clock_now = $urandom;
      end
      send_item(op, key, clock_now);
    end
    drain();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = 48'({$urandom, $urandom});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(ast_pkg::OP_FAN, 48'd0, 32'd0);
    send_item(ast_pkg::OP_KEEP, key_pool[0], 32'd0);
    send_item(ast_pkg::OP_KEEP, key_pool[0], 32'd5);
    send_item(ast_pkg::OP_KEEP, '1, 32'd10);
    send_item(ast_pkg::OP_KEEP, 48'd0, 32'd20);
    send_item(ast_pkg::OP_FAN, '1, 32'd30);
    send_item(ast_pkg::OP_FAN, 48'd0, 32'd200);
    send_item(ast_pkg::OP_KEEP, key_pool[1], 32'd200);
    send_item(ast_pkg::OP_FAN, 48'd0, 32'd200);
    send_item(ast_pkg::OP_KEEP, key_pool[2], '1);
    send_item(ast_pkg::OP_FAN, 48'd0, '1);
    send_item(ast_pkg::OP_FAN, 48'd0, 32'd3);
    drain();

    write_register(ast_pkg::CFG_REPLACE, 16'hFFFF);
    write_register(ast_pkg::CFG_ACTIVE, 16'hFFFF);
    clock_now = 32'd1000;
    hold_off = 600;
    random_phase(0, 80, 72, 1);

    write_register(ast_pkg::CFG_REPLACE, 16'd0);
    write_register(ast_pkg::CFG_ACTIVE, 16'd0);
    random_phase(1, 30, 72, 3);

    write_register(ast_pkg::CFG_REPLACE, 16'd30);
    write_register(ast_pkg::CFG_ACTIVE, 16'd100);
    clock_now = 32'hFFFF_FF00;
    random_phase(2, 35, 20, 8);

    write_register(ast_pkg::CFG_REPLACE, 16'd200);
    write_register(ast_pkg::CFG_ACTIVE, 16'd6);
    random_phase(3, 35, 40, 4);

    write_register(ast_pkg::CFG_REPLACE, ast_pkg::REPLACE_RST);
    write_register(ast_pkg::CFG_ACTIVE, ast_pkg::ACTIVE_RST);
    random_phase(0, 30, 30, 20);

    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("aging_subscriber_table verification clean");
    end else begin
      $display("aging_subscriber_table verification failed");
    end
    $finish;
  end
endmodule
